// ===== design/wsd_pkg.sv =====
// Shared types, codes and constants of the WebSocket frame deframer.
package wsd_pkg;

   // Default width of the frame length counter
   localparam int LENGTH_BITS_DEFAULT = 64;

   // Header byte counts
   localparam int CNT_BITS = 4;
   localparam logic [CNT_BITS-1:0] EXT16_BYTES = 4'd2;
   localparam logic [CNT_BITS-1:0] EXT64_BYTES = 4'd8;
   localparam logic [CNT_BITS-1:0] MASK_BYTES  = 4'd4;

   // Length codes of the second header byte
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Opcodes
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_TEXT  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_PONG  = 2'd2,
      KIND_CLOSE = 2'd3
   } kind_type;

   // Parse phases, one-hot
   typedef enum logic [4:0] {
      PH_HDR0    = 5'b00001,
      PH_HDR1    = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_MASK    = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   // One result item
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic       last;
   } result_type;

endpackage

// ===== design/wsd_input_stage.sv =====
// Input register of the deframer: holds one received byte until the parser takes it.
module wsd_input_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       take,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       accept;

   // Accept a new item whenever the register is empty or drains this cycle
   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// ===== design/wsd_parser.sv =====
// Frame parser of the deframer: header, extended length, mask key and payload unmasking.
module wsd_parser #(
   parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           item_byte,
   output logic                 res_valid,
   output wsd_pkg::result_type  res
);

   wsd_pkg::phase_type              phase_ff, phase_in;
   logic [3:0]                      opcode_ff, opcode_in;
   logic                            mask_on_ff, mask_on_in;
   logic [LENGTH_BITS-1:0]          length_ff, length_in;
   logic [wsd_pkg::CNT_BITS-1:0]    count_ff, count_in;
   logic [31:0]                     key_ff, key_in;
   logic [1:0]                      index_ff, index_in;
   logic                            closed_ff, closed_in;

   logic [LENGTH_BITS-1:0]          length_now;
   logic [wsd_pkg::CNT_BITS-1:0]    count_dec;
   logic [wsd_pkg::CNT_BITS-1:0]    count_inc;
   logic [6:0]                      code;
   logic [7:0]                      key_byte;
   logic                            final_byte;
   logic                            start;
   logic                            frame_end;
   logic                            end_empty;

   assign code      = item_byte[6:0];
   assign count_dec = count_ff - 1'b1;
   assign count_inc = count_ff + 1'b1;

   // Length as it stands after this byte
   always_comb begin
      length_now = length_ff;
      if (phase_ff == wsd_pkg::PH_HDR1) begin
         length_now = LENGTH_BITS'(code);
      end else if (phase_ff == wsd_pkg::PH_EXTLEN) begin
         length_now = {length_ff[LENGTH_BITS-9:0], item_byte};
      end
   end

   // Select the key byte for this payload position
   always_comb begin
      case (index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign final_byte = (length_ff[LENGTH_BITS-1:1] == '0);

   // Advance the phase and build the result
   always_comb begin
      phase_in   = phase_ff;
      opcode_in  = opcode_ff;
      mask_on_in = mask_on_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      index_in   = index_ff;
      closed_in  = closed_ff;
      start      = 1'b0;
      frame_end  = 1'b0;
      end_empty  = 1'b0;
      res_valid  = 1'b0;
      res.kind         = wsd_pkg::KIND_TEXT;
      res.payload_byte = 8'd0;
      res.last         = 1'b0;

      if (step && !closed_ff) begin
         unique case (phase_ff)
            wsd_pkg::PH_HDR0: begin
               opcode_in = item_byte[3:0];
               phase_in  = wsd_pkg::PH_HDR1;
            end
            wsd_pkg::PH_HDR1: begin
               mask_on_in = item_byte[7];
               if (code == wsd_pkg::LEN_CODE_EXT16 || code == wsd_pkg::LEN_CODE_EXT64) begin
                  length_in = '0;
                  count_in  = (code == wsd_pkg::LEN_CODE_EXT16) ?
                              wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
                  phase_in  = wsd_pkg::PH_EXTLEN;
               end else begin
                  length_in = length_now;
                  if (item_byte[7]) begin
                     phase_in = wsd_pkg::PH_MASK;
                     count_in = '0;
                     key_in   = '0;
                  end else begin
                     key_in = '0;
                     start  = 1'b1;
                  end
               end
            end
            wsd_pkg::PH_EXTLEN: begin
               length_in = length_now;
               count_in  = count_dec;
               if (count_dec == '0) begin
                  if (mask_on_ff) begin
                     phase_in = wsd_pkg::PH_MASK;
                     count_in = '0;
                     key_in   = '0;
                  end else begin
                     key_in = '0;
                     start  = 1'b1;
                  end
               end
            end
            wsd_pkg::PH_MASK: begin
               key_in   = {key_ff[23:0], item_byte};
               count_in = count_inc;
               if (count_inc == wsd_pkg::MASK_BYTES) begin
                  count_in = '0;
                  start    = 1'b1;
               end
            end
            wsd_pkg::PH_PAYLOAD: begin
               index_in  = index_ff + 2'd1;
               length_in = final_byte ? '0 : length_ff - 1'b1;
               if (opcode_ff == wsd_pkg::OP_TEXT) begin
                  res_valid        = 1'b1;
                  res.kind         = wsd_pkg::KIND_TEXT;
                  res.payload_byte = item_byte ^ key_byte;
                  res.last         = final_byte;
                  if (final_byte) begin
                     phase_in = wsd_pkg::PH_HDR0;
                  end
               end else if (final_byte) begin
                  frame_end = 1'b1;
               end
            end
            default: begin
               phase_in = wsd_pkg::PH_HDR0;
            end
         endcase

         // Enter the payload, or end an empty frame at once
         if (start) begin
            index_in = 2'd0;
            if (length_now == '0) begin
               frame_end = 1'b1;
               end_empty = 1'b1;
            end else begin
               phase_in = wsd_pkg::PH_PAYLOAD;
            end
         end

         // Give the frame event, if any
         if (frame_end) begin
            phase_in = wsd_pkg::PH_HDR0;
            if (opcode_ff == wsd_pkg::OP_CLOSE) begin
               closed_in = 1'b1;
               res_valid = 1'b1;
               res.kind  = wsd_pkg::KIND_CLOSE;
            end else if (opcode_ff == wsd_pkg::OP_PING) begin
               res_valid = 1'b1;
               res.kind  = wsd_pkg::KIND_PONG;
            end else if (opcode_ff == wsd_pkg::OP_TEXT && end_empty) begin
               res_valid = 1'b1;
               res.kind  = wsd_pkg::KIND_EMPTY;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= wsd_pkg::PH_HDR0;
         opcode_ff  <= '0;
         mask_on_ff <= 1'b0;
         length_ff  <= '0;
         count_ff   <= '0;
         key_ff     <= '0;
         index_ff   <= '0;
         closed_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         opcode_ff  <= opcode_in;
         mask_on_ff <= mask_on_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         key_ff     <= key_in;
         index_ff   <= index_in;
         closed_ff  <= closed_in;
      end
   end

endmodule

// ===== design/wsd_output_stage.sv =====
// Result register of the deframer: holds one result item until the receiver takes it.
module wsd_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  wsd_pkg::result_type res,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,  // [7:0] payload_byte
   output logic [1:0]          rsp_tuser,  // [1:0] kind
   output logic                rsp_tlast
);

   logic                valid_ff;
   logic                valid_in;
   wsd_pkg::result_type res_ff;
   wsd_pkg::result_type res_in;

   // Take a new result when empty or when the held one leaves this cycle
   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff.payload_byte;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.last;

endmodule

// ===== design/websocket_frame_deframer_core.sv =====
// Top level of the WebSocket frame deframer.
//
// Received connection bytes enter on the req_ stream, one byte per item in
// req_tdata. Each byte is registered, parsed against the frame header, the
// extended length and the mask key, and any result is registered on the
// rsp_ stream: rsp_tdata carries the unmasked payload byte, rsp_tuser the
// kind (text byte, empty text frame, pong request, close received) and
// rsp_tlast marks the final payload byte of a text frame.
// A byte accepted at one clock edge has its result on rsp_tvalid from the
// next edge on, provided the result register is free by then.
// Throughput is one byte per cycle while the result register has room,
// set by the single parse step between the input register and the result
// register; bytes that give no result still take a parse step each.
// A synchronous reset empties both registers and returns the parser to
// the first header byte with the stream open. After a close frame every
// byte is taken and dropped until reset.
// When the receiver holds rsp_tready low, the full result register stops
// the parser and req_tready falls once the input register is full too.
module websocket_frame_deframer_core #(
   parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);

   logic                item_valid;
   logic [7:0]          item_byte;
   logic                can_load;
   logic                step;
   logic                res_valid;
   wsd_pkg::result_type res;

   // Parse the held byte whenever the result register has room
   assign step = item_valid && can_load;

   wsd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (step),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   wsd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item_byte (item_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   wsd_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
